// File: rtl/alr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_pkg
// Shared constants, widths, state codes and the controller/datapath
// command and status bundles of the antialiased line rasterizer.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int IMG_W = 256;
    localparam int IMG_H = 256;
    localparam int XB    = $clog2(IMG_W);
    localparam int YB    = $clog2(IMG_H);
    localparam int AW    = XB + YB;

    localparam int INW   = 20;          // input coordinate width, Q.8
    localparam int CW    = 24;          // shifted / flipped coordinate width, Q.8
    localparam int NW    = CW + 16;     // dividend width
    localparam int DCW   = $clog2(NW);  // divider step counter width
    localparam int GW    = 18;          // gradient, signed Q16
    localparam int EW    = 17;          // rounded endpoint position
    localparam int DFW   = 10;          // endpoint rounding residue
    localparam int YEW   = 34;          // endpoint intercept, Q16
    localparam int MW    = 18;          // interior major coordinate
    localparam int PRW   = GW + MW;     // intercept skip product
    localparam int ITW   = 40;          // running intercept, Q16
    localparam int PW    = 25;          // plot coordinate
    localparam int WW    = 25;          // plot weight, Q24
    localparam int CLW   = 16;          // colour channel
    localparam int CPW   = CLW + WW;    // colour times weight
    localparam int PXW   = 3 * CLW;     // stored pixel
    localparam int LCW   = 11;          // landed plot count

    localparam logic CFG_SHIFT_X = 1'b0;
    localparam logic CFG_SHIFT_Y = 1'b1;

    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [16:0] {
        S_CLEAR = 17'h00001,
        S_IDLE  = 17'h00002,
        S_RD    = 17'h00004,
        S_PREP1 = 17'h00008,
        S_PREP2 = 17'h00010,
        S_DIVI  = 17'h00020,
        S_DIV   = 17'h00040,
        S_EPA   = 17'h00080,
        S_EPB   = 17'h00100,
        S_PA    = 17'h00200,
        S_PB    = 17'h00400,
        S_PC    = 17'h00800,
        S_INTA  = 17'h01000,
        S_INTB  = 17'h02000,
        S_LOOP  = 17'h04000,
        S_STEP  = 17'h08000,
        S_FIN   = 17'h10000
    } t_state;

    typedef enum logic [2:0] {
        PH_E0L,
        PH_E0H,
        PH_E1L,
        PH_E1H,
        PH_IL,
        PH_IH
    } t_phase;

    typedef struct packed {
        logic cap;
        logic clr_en;
        logic rd_issue;
        logic prep1;
        logic prep2;
        logic div_init;
        logic div_step;
        logic ep_a;
        logic ep_b;
        logic ep_sel;
        logic int_a;
        logic int_b;
        logic step;
        logic plot_a;
        logic plot_b;
        logic plot_c;
        logic p_int;
        logic p_hi;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic loop_go;
    } t_stat;

endpackage

// File: rtl/alr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_ctrl
// Sequencer: clearing pass, item capture, gradient division, endpoint and
// interior plot sequencing, result hand-off.
// ----------------------------------------------------------------------------
module alr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_func,
    input  logic          i_stall,
    input  alr_pkg::t_stat i_stat,
    output alr_pkg::t_cmd  o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    alr_pkg::t_state r_st, n_st;
    alr_pkg::t_phase r_ph, n_ph;
    logic            r_ovld, n_ovld;
    alr_pkg::t_cmd   w_cmd;

    always_comb begin
        w_cmd  = '0;
        n_st   = r_st;
        n_ph   = r_ph;
        case (r_st)
            alr_pkg::S_CLEAR: begin
                w_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) begin
                    n_st = alr_pkg::S_IDLE;
                end
            end
            alr_pkg::S_IDLE: begin
                if (i_valid) begin
                    w_cmd.cap = 1'b1;
                    n_st = (i_func == alr_pkg::FUNC_READ) ? alr_pkg::S_RD : alr_pkg::S_PREP1;
                end
            end
            alr_pkg::S_RD: begin
                w_cmd.rd_issue = 1'b1;
                n_st = alr_pkg::S_FIN;
            end
            alr_pkg::S_PREP1: begin
                w_cmd.prep1 = 1'b1;
                n_st = alr_pkg::S_PREP2;
            end
            alr_pkg::S_PREP2: begin
                w_cmd.prep2 = 1'b1;
                n_st = alr_pkg::S_DIVI;
            end
            alr_pkg::S_DIVI: begin
                w_cmd.div_init = 1'b1;
                n_st = alr_pkg::S_DIV;
            end
            alr_pkg::S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_st = alr_pkg::S_EPA;
                    n_ph = alr_pkg::PH_E0L;
                end
            end
            alr_pkg::S_EPA: begin
                w_cmd.ep_a   = 1'b1;
                w_cmd.ep_sel = (r_ph == alr_pkg::PH_E1L);
                n_st = alr_pkg::S_EPB;
            end
            alr_pkg::S_EPB: begin
                w_cmd.ep_b   = 1'b1;
                w_cmd.ep_sel = (r_ph == alr_pkg::PH_E1L);
                n_st = alr_pkg::S_PA;
            end
            alr_pkg::S_PA: begin
                w_cmd.plot_a = 1'b1;
                w_cmd.p_int  = (r_ph == alr_pkg::PH_IL) || (r_ph == alr_pkg::PH_IH);
                w_cmd.p_hi   = (r_ph == alr_pkg::PH_E0H) || (r_ph == alr_pkg::PH_E1H) ||
                               (r_ph == alr_pkg::PH_IH);
                n_st = alr_pkg::S_PB;
            end
            alr_pkg::S_PB: begin
                w_cmd.plot_b = 1'b1;
                n_st = alr_pkg::S_PC;
            end
            alr_pkg::S_PC: begin
                w_cmd.plot_c = 1'b1;
                case (r_ph)
                    alr_pkg::PH_E0L: begin
                        n_ph = alr_pkg::PH_E0H;
                        n_st = alr_pkg::S_PA;
                    end
                    alr_pkg::PH_E0H: begin
                        n_ph = alr_pkg::PH_E1L;
                        n_st = alr_pkg::S_EPA;
                    end
                    alr_pkg::PH_E1L: begin
                        n_ph = alr_pkg::PH_E1H;
                        n_st = alr_pkg::S_PA;
                    end
                    alr_pkg::PH_E1H: begin
                        n_st = alr_pkg::S_INTA;
                    end
                    alr_pkg::PH_IL: begin
                        n_ph = alr_pkg::PH_IH;
                        n_st = alr_pkg::S_PA;
                    end
                    default: begin
                        n_st = alr_pkg::S_STEP;
                    end
                endcase
            end
            alr_pkg::S_INTA: begin
                w_cmd.int_a = 1'b1;
                n_st = alr_pkg::S_INTB;
            end
            alr_pkg::S_INTB: begin
                w_cmd.int_b = 1'b1;
                n_st = alr_pkg::S_LOOP;
            end
            alr_pkg::S_LOOP: begin
                if (i_stat.loop_go) begin
                    n_ph = alr_pkg::PH_IL;
                    n_st = alr_pkg::S_PA;
                end else begin
                    n_st = alr_pkg::S_FIN;
                end
            end
            alr_pkg::S_STEP: begin
                w_cmd.step = 1'b1;
                n_st = alr_pkg::S_LOOP;
            end
            alr_pkg::S_FIN: begin
                if (!r_ovld || !i_stall) begin
                    w_cmd.res_load = 1'b1;
                    n_st = alr_pkg::S_IDLE;
                end
            end
            default: begin
                n_st = alr_pkg::S_IDLE;
            end
        endcase
        n_ovld = w_cmd.res_load ? 1'b1 : (r_ovld && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= alr_pkg::S_CLEAR;
            r_ph   <= alr_pkg::PH_E0L;
            r_ovld <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_ph   <= n_ph;
            r_ovld <= n_ovld;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = (r_st != alr_pkg::S_IDLE);
    assign o_out_valid = r_ovld;

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && i_stall |=> r_ovld)
        else $error("pending result dropped while stalled");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == alr_pkg::S_DIV) && !i_stat.div_last |=> (r_st == alr_pkg::S_DIV))
        else $error("divider left before its last step");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == alr_pkg::S_PC) |-> $past(r_st == alr_pkg::S_PB))
        else $error("plot write without preceding read");

endmodule

// File: rtl/alr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_dp
// Datapath: origin registers, endpoint setup, bit-serial gradient divider,
// intercept walk, weighted read-modify-write plots into the frame memory.
// ----------------------------------------------------------------------------
module alr_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  alr_pkg::t_cmd                   i_cmd,
    output alr_pkg::t_stat                  o_stat,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic signed [alr_pkg::INW-1:0]  i_cfg_data,
    input  logic                            i_func,
    input  logic signed [alr_pkg::INW-1:0]  i_start_x,
    input  logic signed [alr_pkg::INW-1:0]  i_start_y,
    input  logic signed [alr_pkg::INW-1:0]  i_end_x,
    input  logic signed [alr_pkg::INW-1:0]  i_end_y,
    input  logic        [alr_pkg::CLW-1:0]  i_color_red,
    input  logic        [alr_pkg::CLW-1:0]  i_color_green,
    input  logic        [alr_pkg::CLW-1:0]  i_color_blue,
    input  logic        [alr_pkg::XB-1:0]   i_pixel_col,
    input  logic        [alr_pkg::YB-1:0]   i_pixel_row,
    output logic        [alr_pkg::CLW-1:0]  o_read_red,
    output logic        [alr_pkg::CLW-1:0]  o_read_green,
    output logic        [alr_pkg::CLW-1:0]  o_read_blue,
    output logic        [alr_pkg::LCW-1:0]  o_plots_landed
);

    localparam int CW  = alr_pkg::CW;
    localparam int NW  = alr_pkg::NW;
    localparam int GW  = alr_pkg::GW;
    localparam int CLW = alr_pkg::CLW;

    logic [alr_pkg::PXW-1:0] mem [0:(2**alr_pkg::AW)-1];

    logic signed [alr_pkg::INW-1:0] r_shx, r_shy;
    logic [alr_pkg::AW-1:0]         r_clr;
    logic [alr_pkg::LCW-1:0]        r_landed;
    logic [alr_pkg::DCW-1:0]        r_dcnt;

    logic                           r_func;
    logic signed [alr_pkg::INW-1:0] r_ix0, r_iy0, r_ix1, r_iy1;
    logic [CLW-1:0]                 r_cr, r_cg, r_cb;
    logic [alr_pkg::XB-1:0]         r_pcol;
    logic [alr_pkg::YB-1:0]         r_prow;

    logic signed [CW-1:0] r_X0, r_X1, r_Y0, r_Y1;
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1;
    logic                 r_steep;
    logic [CW-1:0]        r_dx;
    logic                 r_neg;
    logic [NW-1:0]        r_num;
    logic [CW-1:0]        r_rem;

    logic signed [alr_pkg::EW-1:0]  r_ex, r_xa, r_xb;
    logic signed [alr_pkg::DFW-1:0] r_ediff;
    logic [8:0]                     r_gap;
    logic signed [CW-1:0]           r_ey;
    logic signed [alr_pkg::YEW-1:0] r_yend, r_ya;
    logic signed [alr_pkg::MW-1:0]  r_m, r_stop;
    logic signed [alr_pkg::PRW-1:0] r_iprod;
    logic signed [alr_pkg::ITW-1:0] r_inter;

    logic [alr_pkg::AW-1:0]  r_paddr;
    logic                    r_pin;
    logic [alr_pkg::WW-1:0]  r_w;
    logic [alr_pkg::CPW-1:0] r_pr_r, r_pr_g, r_pr_b;
    logic [alr_pkg::PXW-1:0] r_rdata;

    logic [CLW-1:0]          r_or, r_og, r_ob;
    logic [alr_pkg::LCW-1:0] r_ocnt;

    // shift and flip
    logic signed [CW-1:0] w_X0, w_X1, w_Y0, w_Y1;
    // axis ordering
    logic signed [CW-1:0] w_dxa, w_dya, w_adx, w_ady0;
    logic signed [CW-1:0] w_a0, w_b0, w_a1, w_b1;
    logic                 w_steep, w_swap;
    // divider
    logic signed [CW-1:0] w_dy;
    logic [CW-1:0]        w_ady;
    logic [CW:0]          w_t;
    logic                 w_ge;
    logic signed [GW-1:0] w_q, w_g;
    // endpoint
    logic signed [CW-1:0]           w_ex, w_ey;
    logic signed [CW:0]             w_exw, w_rpos, w_rneg, w_rnd;
    logic signed [CW+1:0]           w_diff;
    logic [7:0]                     w_fr;
    logic signed [GW+alr_pkg::DFW-1:0] w_gd;
    logic signed [alr_pkg::YEW-1:0] w_yend;
    // interior setup
    logic signed [alr_pkg::MW-1:0]  w_xa1, w_start, w_stop, w_sd;
    // plot
    logic [15:0]                    w_f;
    logic [16:0]                    w_fw;
    logic signed [alr_pkg::PW-1:0]  w_minb, w_min, w_maj, w_px, w_py;
    logic [alr_pkg::WW-1:0]         w_w;
    logic                           w_in;
    logic [CLW:0]                   w_sr, w_sg, w_sb;
    logic [alr_pkg::PXW-1:0]        w_sum;
    // memory port
    logic                           w_we, w_re;
    logic [alr_pkg::AW-1:0]         w_waddr, w_raddr;
    logic [alr_pkg::PXW-1:0]        w_wdata;

    always_comb begin
        w_X0 = CW'(r_ix0) + CW'(r_shx);
        w_X1 = CW'(r_ix1) + CW'(r_shx);
        w_Y0 = CW'(alr_pkg::IMG_H * 256) - (CW'(r_iy0) + CW'(r_shy));
        w_Y1 = CW'(alr_pkg::IMG_H * 256) - (CW'(r_iy1) + CW'(r_shy));

        w_dxa   = r_X1 - r_X0;
        w_dya   = r_Y1 - r_Y0;
        w_adx   = (w_dxa < 0) ? -w_dxa : w_dxa;
        w_ady0  = (w_dya < 0) ? -w_dya : w_dya;
        w_steep = (w_ady0 > w_adx);
        w_a0    = w_steep ? r_Y0 : r_X0;
        w_b0    = w_steep ? r_X0 : r_Y0;
        w_a1    = w_steep ? r_Y1 : r_X1;
        w_b1    = w_steep ? r_X1 : r_Y1;
        w_swap  = (w_a0 > w_a1);

        w_dy  = r_y1 - r_y0;
        w_ady = (w_dy < 0) ? CW'(-w_dy) : CW'(w_dy);
        w_t   = {r_rem, r_num[NW-1]};
        w_ge  = (w_t >= {1'b0, r_dx});
        w_q   = $signed({1'b0, r_num[GW-2:0]});
        if (r_dx == '0) begin
            w_g = GW'(65536);
        end else begin
            w_g = r_neg ? -w_q : w_q;
        end

        w_ex   = i_cmd.ep_sel ? r_x1 : r_x0;
        w_ey   = i_cmd.ep_sel ? r_y1 : r_y0;
        w_exw  = (CW+1)'(w_ex);
        w_rpos = (w_exw + (CW+1)'(128)) >>> 8;
        w_rneg = -((-w_exw + (CW+1)'(128)) >>> 8);
        w_rnd  = (w_ex < 0) ? w_rneg : w_rpos;
        w_diff = ((CW+2)'(w_rnd) <<< 8) - (CW+2)'(w_ex);
        w_fr   = 8'(w_ex + CW'(128));

        w_gd   = w_g * r_ediff;
        w_yend = (alr_pkg::YEW'(r_ey) <<< 8) + alr_pkg::YEW'(w_gd >>> 8);

        w_xa1   = alr_pkg::MW'(r_xa) + alr_pkg::MW'(1);
        w_start = (w_xa1 < 1) ? alr_pkg::MW'(1) : w_xa1;
        w_stop  = (alr_pkg::MW'(r_xb) < alr_pkg::MW'(alr_pkg::IMG_W)) ?
                  alr_pkg::MW'(r_xb) : alr_pkg::MW'(alr_pkg::IMG_W);
        w_sd    = w_start - alr_pkg::MW'(r_xa);

        w_f    = i_cmd.p_int ? r_inter[15:0] : r_yend[15:0];
        w_minb = i_cmd.p_int ? alr_pkg::PW'(r_inter >>> 16) : alr_pkg::PW'(r_yend >>> 16);
        w_min  = w_minb + (i_cmd.p_hi ? alr_pkg::PW'(1) : alr_pkg::PW'(0));
        w_maj  = i_cmd.p_int ? alr_pkg::PW'(r_m) : alr_pkg::PW'(r_ex);
        w_fw   = i_cmd.p_hi ? {1'b0, w_f} : (17'h10000 - {1'b0, w_f});
        w_w    = i_cmd.p_int ? alr_pkg::WW'({w_fw, 8'h00}) : alr_pkg::WW'(w_fw * r_gap);
        w_px   = r_steep ? w_min : w_maj;
        w_py   = r_steep ? w_maj : w_min;
        w_in   = (w_px > 0) && (w_py > 0) &&
                 (w_px < alr_pkg::PW'(alr_pkg::IMG_W)) && (w_py < alr_pkg::PW'(alr_pkg::IMG_H));

        w_sr  = {1'b0, r_rdata[3*CLW-1:2*CLW]} + {1'b0, r_pr_r[CLW+23:24]};
        w_sg  = {1'b0, r_rdata[2*CLW-1:CLW]}   + {1'b0, r_pr_g[CLW+23:24]};
        w_sb  = {1'b0, r_rdata[CLW-1:0]}       + {1'b0, r_pr_b[CLW+23:24]};
        w_sum = {(w_sr[CLW] ? {CLW{1'b1}} : w_sr[CLW-1:0]),
                 (w_sg[CLW] ? {CLW{1'b1}} : w_sg[CLW-1:0]),
                 (w_sb[CLW] ? {CLW{1'b1}} : w_sb[CLW-1:0])};

        w_we    = i_cmd.clr_en || (i_cmd.plot_c && r_pin);
        w_waddr = i_cmd.clr_en ? r_clr : r_paddr;
        w_wdata = i_cmd.clr_en ? '0 : w_sum;
        w_re    = i_cmd.rd_issue || i_cmd.plot_b;
        w_raddr = i_cmd.rd_issue ? {r_prow, r_pcol} : r_paddr;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shx    <= '0;
            r_shy    <= '0;
            r_clr    <= '0;
            r_landed <= '0;
            r_dcnt   <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == alr_pkg::CFG_SHIFT_X)) begin
                r_shx <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == alr_pkg::CFG_SHIFT_Y)) begin
                r_shy <= i_cfg_data;
            end
            if (i_cmd.clr_en) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.cap) begin
                r_landed <= '0;
            end else if (i_cmd.plot_c && r_pin && (r_landed != '1)) begin
                r_landed <= r_landed + 1'b1;
            end
            if (i_cmd.div_init) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func <= i_func;
            r_ix0  <= i_start_x;
            r_iy0  <= i_start_y;
            r_ix1  <= i_end_x;
            r_iy1  <= i_end_y;
            r_cr   <= i_color_red;
            r_cg   <= i_color_green;
            r_cb   <= i_color_blue;
            r_pcol <= i_pixel_col;
            r_prow <= i_pixel_row;
        end
        if (i_cmd.prep1) begin
            r_X0 <= w_X0;
            r_X1 <= w_X1;
            r_Y0 <= w_Y0;
            r_Y1 <= w_Y1;
        end
        if (i_cmd.prep2) begin
            r_steep <= w_steep;
            r_x0    <= w_swap ? w_a1 : w_a0;
            r_y0    <= w_swap ? w_b1 : w_b0;
            r_x1    <= w_swap ? w_a0 : w_a1;
            r_y1    <= w_swap ? w_b0 : w_b1;
        end
        if (i_cmd.div_init) begin
            r_dx  <= CW'(r_x1 - r_x0);
            r_neg <= (w_dy < 0);
            r_num <= {w_ady, 16'h0000};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? CW'(w_t - {1'b0, r_dx}) : w_t[CW-1:0];
            r_num <= {r_num[NW-2:0], w_ge};
        end
        if (i_cmd.ep_a) begin
            r_ex    <= alr_pkg::EW'(w_rnd);
            r_ediff <= alr_pkg::DFW'(w_diff);
            r_ey    <= w_ey;
            r_gap   <= i_cmd.ep_sel ? {1'b0, w_fr} : (9'd256 - {1'b0, w_fr});
        end
        if (i_cmd.ep_b) begin
            r_yend <= w_yend;
            if (i_cmd.ep_sel) begin
                r_xb <= r_ex;
            end else begin
                r_xa <= r_ex;
                r_ya <= w_yend;
            end
        end
        if (i_cmd.int_a) begin
            r_m     <= w_start;
            r_stop  <= w_stop;
            r_iprod <= w_g * w_sd;
        end
        if (i_cmd.int_b) begin
            r_inter <= alr_pkg::ITW'(r_ya) + alr_pkg::ITW'(r_iprod);
        end else if (i_cmd.step) begin
            r_inter <= r_inter + alr_pkg::ITW'(w_g);
            r_m     <= r_m + alr_pkg::MW'(1);
        end
        if (i_cmd.plot_a) begin
            r_paddr <= {w_py[alr_pkg::YB-1:0], w_px[alr_pkg::XB-1:0]};
            r_pin   <= w_in;
            r_w     <= w_w;
        end
        if (i_cmd.plot_b) begin
            r_pr_r <= r_cr * r_w;
            r_pr_g <= r_cg * r_w;
            r_pr_b <= r_cb * r_w;
        end
        if (i_cmd.res_load) begin
            if (r_func == alr_pkg::FUNC_READ) begin
                r_or   <= r_rdata[3*CLW-1:2*CLW];
                r_og   <= r_rdata[2*CLW-1:CLW];
                r_ob   <= r_rdata[CLW-1:0];
                r_ocnt <= '0;
            end else begin
                r_or   <= '0;
                r_og   <= '0;
                r_ob   <= '0;
                r_ocnt <= r_landed;
            end
        end
    end

    assign o_stat.clr_last = (r_clr == '1);
    assign o_stat.div_last = (r_dcnt == alr_pkg::DCW'(NW - 1));
    assign o_stat.loop_go  = (r_m < r_stop);

    assign o_read_red     = r_or;
    assign o_read_green   = r_og;
    assign o_read_blue    = r_ob;
    assign o_plots_landed = r_ocnt;

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.plot_c && r_pin && (r_landed != '1) |=> (r_landed == $past(r_landed) + 1'b1))
        else $error("landed count missed a plot");

endmodule

// File: rtl/antialiased_line_raster_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// antialiased_line_raster_top
// Read item: captured, then the addressed pixel is read and handed out as the result.
// Draw item: the 40-step gradient divider runs, then two endpoint columns and N
//   interior columns (0..255) are plotted, two plots per column, each an address,
//   read and write step on the frame memory. One item is worked at a time.
// Reset: origin shifts clear; a clearing pass over all 65536 addresses zeroes the frame
//   memory, during which no item is taken.
// ----------------------------------------------------------------------------
module antialiased_line_raster_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic signed [alr_pkg::INW-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_func,
    input  logic signed [alr_pkg::INW-1:0]  i_start_x,
    input  logic signed [alr_pkg::INW-1:0]  i_start_y,
    input  logic signed [alr_pkg::INW-1:0]  i_end_x,
    input  logic signed [alr_pkg::INW-1:0]  i_end_y,
    input  logic        [alr_pkg::CLW-1:0]  i_color_red,
    input  logic        [alr_pkg::CLW-1:0]  i_color_green,
    input  logic        [alr_pkg::CLW-1:0]  i_color_blue,
    input  logic        [alr_pkg::XB-1:0]   i_pixel_col,
    input  logic        [alr_pkg::YB-1:0]   i_pixel_row,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic        [alr_pkg::CLW-1:0]  o_read_red,
    output logic        [alr_pkg::CLW-1:0]  o_read_green,
    output logic        [alr_pkg::CLW-1:0]  o_read_blue,
    output logic        [alr_pkg::LCW-1:0]  o_plots_landed
);

    alr_pkg::t_cmd  w_cmd;
    alr_pkg::t_stat w_stat;

    alr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .i_stall     (i_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    alr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_func),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_color_red    (i_color_red),
        .i_color_green  (i_color_green),
        .i_color_blue   (i_color_blue),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .o_read_red     (o_read_red),
        .o_read_green   (o_read_green),
        .o_read_blue    (o_read_blue),
        .o_plots_landed (o_plots_landed)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the antialiased line rasterizer. A queue of draw
// and read requests, filled phase by phase under several origin shifts, feeds
// a clocked driver; a shadow frame buffer predicts each result, and a clocked
// monitor compares every transfer out with the oldest prediction. Both sides
// idle in short random bursts, except in the final phase.
// ----------------------------------------------------------------------------
module testbench;

    localparam longint PX      = 256;
    localparam longint S20_MAX = 524287;
    localparam longint S20_MIN = -524288;
    localparam int     WD_LIMIT = 200000;

    typedef struct {
        logic              func;
        logic signed [19:0] sx, sy, ex, ey;
        logic [15:0]       r, g, b;
        logic [7:0]        col, row;
    } t_raster_req;

    typedef struct {
        logic [15:0] r, g, b;
        logic [10:0] landed;
    } t_raster_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = alr_pkg::CFG_SHIFT_X;
    logic signed [19:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_func = alr_pkg::FUNC_DRAW;
    logic signed [19:0] i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic [15:0] i_color_red = '0, i_color_green = '0, i_color_blue = '0;
    logic [7:0] i_pixel_col = '0, i_pixel_row = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [15:0] o_read_red, o_read_green, o_read_blue;
    logic [10:0] o_plots_landed;

    antialiased_line_raster_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_func(i_func),
        .i_start_x(i_start_x), .i_start_y(i_start_y),
        .i_end_x(i_end_x), .i_end_y(i_end_y),
        .i_color_red(i_color_red), .i_color_green(i_color_green),
        .i_color_blue(i_color_blue),
        .i_pixel_col(i_pixel_col), .i_pixel_row(i_pixel_row),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_read_red(o_read_red), .o_read_green(o_read_green),
        .o_read_blue(o_read_blue), .o_plots_landed(o_plots_landed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_raster_req pending_reqs[$];
    t_raster_rsp expected_px[$];
    logic [47:0] shadow_fb [0:65535];
    longint shift_x = 0, shift_y = 0;
    longint line_rgb [3];
    int     landed_cnt;
    int     fails = 0;
    bit     quiet = 0;
    int     drv_gap = 0, mon_gap = 0, idle_cycles = 0;
    longint last_x0 = 100 * PX, last_y0 = 100 * PX, last_x1 = 120 * PX, last_y1 = 110 * PX;

    // ---------------- shadow rasterizer ----------------
    function automatic longint round_px(longint v);
        return (v >= 0) ? ((v + 128) >>> 8) : -((-v + 128) >>> 8);
    endfunction

    function automatic void deposit_px(longint x, longint y, longint w24);
        logic [47:0] cur;
        longint s;
        int k;
        if (x <= 0 || y <= 0 || x >= alr_pkg::IMG_W || y >= alr_pkg::IMG_H) return;
        cur = shadow_fb[y * alr_pkg::IMG_W + x];
        for (k = 0; k < 3; k++) begin
            s = longint'(cur[k*16 +: 16]) + ((line_rgb[k] * w24) >>> 24);
            cur[k*16 +: 16] = (s > 65535) ? 16'hFFFF : s[15:0];
        end
        shadow_fb[y * alr_pkg::IMG_W + x] = cur;
        if (landed_cnt < 2047) landed_cnt++;
    endfunction

    function automatic void deposit_major(bit steep, longint m, longint s, longint w24);
        if (steep) deposit_px(s, m, w24);
        else deposit_px(m, s, w24);
    endfunction

    function automatic longint edge_point(bit steep, longint x, longint y, longint g,
                                          longint gap, output longint xpx);
        longint xend, yend, ypx, f;
        xend = round_px(x);
        yend = y * 256 + ((g * (xend * 256 - x)) >>> 8);
        ypx  = yend >>> 16;
        f    = yend & 64'hFFFF;
        deposit_major(steep, xend, ypx, (65536 - f) * gap);
        deposit_major(steep, xend, ypx + 1, f * gap);
        xpx = xend;
        return yend;
    endfunction

    function automatic void raster_line(longint x0, longint y0, longint x1, longint y1);
        longint t, dx, dy, g, xa, xb, ya, first, last, lim, icpt, m, f;
        bit steep;
        x0 += shift_x;
        x1 += shift_x;
        y0 = alr_pkg::IMG_H * PX - (y0 + shift_y);
        y1 = alr_pkg::IMG_H * PX - (y1 + shift_y);
        dx = x1 - x0;
        dy = y1 - y0;
        steep = ((dy < 0) ? -dy : dy) > ((dx < 0) ? -dx : dx);
        if (steep) begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        dx = x1 - x0;
        dy = y1 - y0;
        g = (dx == 0) ? 65536 : (dy * 65536) / dx;
        ya = edge_point(steep, x0, y0, g, 256 - ((x0 + 128) & 255), xa);
        void'(edge_point(steep, x1, y1, g, (x1 + 128) & 255, xb));
        lim = steep ? alr_pkg::IMG_H : alr_pkg::IMG_W;
        first = (xa + 1 < 1) ? 1 : xa + 1;
        last = (xb < lim) ? xb : lim;
        icpt = ya + g * (first - xa);
        for (m = first; m < last; m++) begin
            f = icpt & 64'hFFFF;
            deposit_major(steep, m, icpt >>> 16, (65536 - f) << 8);
            deposit_major(steep, m, (icpt >>> 16) + 1, f << 8);
            icpt += g;
        end
    endfunction

    function automatic t_raster_rsp predict_px(t_raster_req q);
        t_raster_rsp p;
        logic [47:0] v;
        p = '{16'h0, 16'h0, 16'h0, 11'h0};
        if (q.func == alr_pkg::FUNC_READ) begin
            v = shadow_fb[q.row * alr_pkg::IMG_W + q.col];
            p.r = v[15:0];
            p.g = v[31:16];
            p.b = v[47:32];
        end else begin
            line_rgb[0] = q.r;
            line_rgb[1] = q.g;
            line_rgb[2] = q.b;
            landed_cnt = 0;
            raster_line(q.sx, q.sy, q.ex, q.ey);
            p.landed = landed_cnt[10:0];
        end
        return p;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic signed [19:0] clamp20(longint v);
        longint c;
        c = (v > S20_MAX) ? S20_MAX : ((v < S20_MIN) ? S20_MIN : v);
        return c[19:0];
    endfunction

    function automatic void push_raw(logic func, longint sx, longint sy, longint ex,
                                     longint ey, int r, int g, int b, int col, int row);
        t_raster_req q;
        q.func = func;
        q.sx = clamp20(sx); q.sy = clamp20(sy);
        q.ex = clamp20(ex); q.ey = clamp20(ey);
        q.r = r[15:0]; q.g = g[15:0]; q.b = b[15:0];
        q.col = col[7:0]; q.row = row[7:0];
        pending_reqs.push_back(q);
    endfunction

    // screen-space endpoints (Q.8, y downward) under the current shifts
    function automatic void push_line(longint x0, longint y0, longint x1, longint y1,
                                      int r, int g, int b);
        last_x0 = x0; last_y0 = y0; last_x1 = x1; last_y1 = y1;
        push_raw(alr_pkg::FUNC_DRAW, x0 - shift_x, alr_pkg::IMG_H * PX - y0 - shift_y,
                 x1 - shift_x, alr_pkg::IMG_H * PX - y1 - shift_y, r, g, b,
                 $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    function automatic void push_read_near();
        longint t, x, y;
        t = $urandom_range(0, 256);
        x = (last_x0 + ((last_x1 - last_x0) * t) / 256) >>> 8;
        y = (last_y0 + ((last_y1 - last_y0) * t) / 256) >>> 8;
        x += $urandom_range(0, 2) - 1;
        y += $urandom_range(0, 2) - 1;
        x = (x < 0) ? 0 : ((x > 255) ? 255 : x);
        y = (y < 0) ? 0 : ((y > 255) ? 255 : y);
        push_raw(alr_pkg::FUNC_READ, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, x, y);
    endfunction

    function automatic int pick_color();
        return ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(0, 65535);
    endfunction

    function automatic void fill_random(int n);
        int k, sel;
        longint x0, y0, span;
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                if (sel < 20) push_read_near();
                else push_raw(alr_pkg::FUNC_READ, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (sel < 38) begin
                push_raw(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                span = ($urandom_range(0, 6) == 0) ? 300 * PX : 24 * PX;
                x0 = $urandom_range(0, 262 * PX) - 3 * PX;
                y0 = $urandom_range(0, 262 * PX) - 3 * PX;
                push_line(x0, y0, x0 + $urandom_range(0, 2 * span) - span,
                          y0 + $urandom_range(0, 2 * span) - span,
                          pick_color(), pick_color(), pick_color());
            end
        end
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || expected_px.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, longint v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[19:0];
        if (idx == alr_pkg::CFG_SHIFT_X) shift_x = v;
        else shift_y = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(longint sx, longint sy, int n);
        wait_idle();
        cfg_write(alr_pkg::CFG_SHIFT_X, sx);
        cfg_write(alr_pkg::CFG_SHIFT_Y, sy);
        fill_random(n);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        t_raster_req q;
        logic nxt_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_valid = i_valid;
            if (i_valid && !o_stall) begin
                expected_px.push_back(predict_px('{i_func, i_start_x, i_start_y,
                    i_end_x, i_end_y, i_color_red, i_color_green, i_color_blue,
                    i_pixel_col, i_pixel_row}));
                nxt_valid = 1'b0;
                if (!quiet && $urandom_range(0, 3) == 0) drv_gap = $urandom_range(1, 3);
            end
            if (!nxt_valid) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_reqs.size() != 0) begin
                    q = pending_reqs.pop_front();
                    i_func <= q.func;
                    i_start_x <= q.sx; i_start_y <= q.sy;
                    i_end_x <= q.ex; i_end_y <= q.ey;
                    i_color_red <= q.r; i_color_green <= q.g; i_color_blue <= q.b;
                    i_pixel_col <= q.col; i_pixel_row <= q.row;
                    nxt_valid = 1'b1;
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_raster_rsp e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_px.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    fails++;
                end else begin
                    e = expected_px.pop_front();
                    if (o_read_red !== e.r) begin
                        $error("read_red: expected %0d, got %0d", e.r, o_read_red);
                        fails++;
                    end
                    if (o_read_green !== e.g) begin
                        $error("read_green: expected %0d, got %0d", e.g, o_read_green);
                        fails++;
                    end
                    if (o_read_blue !== e.b) begin
                        $error("read_blue: expected %0d, got %0d", e.b, o_read_blue);
                        fails++;
                    end
                    if (o_plots_landed !== e.landed) begin
                        $error("plots_landed: expected %0d, got %0d",
                               e.landed, o_plots_landed);
                        fails++;
                    end
                end
            end
            if (mon_gap > 0) begin
                i_stall <= 1'b1;
                mon_gap--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                mon_gap = $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        int k;
        for (k = 0; k < 65536; k++) shadow_fb[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // clipped horizontal, steep near-vertical, single point, diagonal
        push_line(-10 * PX, 100 * PX, 300 * PX, 100 * PX + 128, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_line(50 * PX, -5 * PX, 50 * PX + 77, 270 * PX, 16'h8000, 16'h1234, 16'hFFFF);
        push_line(80 * PX, 80 * PX, 80 * PX, 80 * PX, 16'hFFFF, 16'h0000, 16'hABCD);
        push_line(10 * PX, 10 * PX, 200 * PX, 200 * PX, 16'h7FFF, 16'hFFFF, 16'h0001);
        push_raw(alr_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 100, 100);
        // reversed steep, line on the left edge, fractional endpoints
        push_line(120 * PX, 200 * PX, 110 * PX, 20 * PX, 16'hFFFF, 16'hFFFF, 16'h0000);
        push_line(0, 30 * PX, 0, 60 * PX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_line(20 * PX + 37, 40 * PX + 200, 60 * PX + 129, 45 * PX + 3,
                  16'h4321, 16'hFEDC, 16'h0F0F);
        // saturate by overdrawing
        for (k = 0; k < 3; k++)
            push_line(30 * PX, 150 * PX, 90 * PX, 160 * PX, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (k = 0; k < 3; k++) push_read_near();
        push_raw(alr_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_raw(alr_pkg::FUNC_READ, S20_MAX, S20_MIN, S20_MAX, S20_MIN,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 255);
        push_raw(alr_pkg::FUNC_DRAW, S20_MAX, S20_MAX, S20_MIN, S20_MIN, 0, 0, 0, 255, 0);
        push_raw(alr_pkg::FUNC_DRAW, S20_MIN, S20_MAX, S20_MAX, S20_MIN,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 255);
        push_raw(alr_pkg::FUNC_DRAW, S20_MIN, S20_MIN, S20_MIN, S20_MIN, 0, 0, 0, 0, 0);
        push_raw(alr_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 1, 255);
        push_raw(alr_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 255, 1);

        fill_random(150);
        run_phase(S20_MAX, S20_MIN, 100);
        run_phase(S20_MIN, S20_MAX, 100);
        run_phase($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048, 180);
        run_phase(0, 128, 180);
        run_phase($signed(20'($urandom)), $signed(20'($urandom)), 100);
        wait_idle();
        quiet = 1;
        run_phase(0, 0, 80);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fails == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule
